// ----- hdl/raid0_stripe_request_splitter_defines.svh -----
// assertion macros for the raid0 stripe request splitter
// expects signals named clock and reset in the module that uses them
`ifndef RAID0_STRIPE_REQUEST_SPLITTER_DEFINES_SVH
`define RAID0_STRIPE_REQUEST_SPLITTER_DEFINES_SVH

// same-cycle implication
`define R0S_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("r0split: same-cycle check failed");

// next-cycle implication
`define R0S_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("r0split: next-cycle check failed");

`endif

// ----- hdl/r0split_pkg.sv -----
// shared types and constants for the raid0 stripe request splitter
// no dependencies
`timescale 1ns / 1ps

package r0split_pkg;

   localparam int OFFSET_W     = 48;
   localparam int LEN_W        = 25;
   localparam int BLOCK_W      = 17;
   localparam int ADDR_W       = 47;
   localparam int DIV_STEPS    = OFFSET_W;
   localparam int DIV_COUNT_W  = $clog2(DIV_STEPS);
   localparam int MAX_SEGMENTS = 64;
   localparam int SPAN_W       = LEN_W + 1;

   localparam logic [BLOCK_W-1:0] BLOCK_RESET = BLOCK_W'(512);

   typedef struct packed {
      logic                mode;
      logic [OFFSET_W-1:0] volume_byte_offset;
      logic [LEN_W-1:0]    request_bytes;
   } req_type;

   typedef struct packed {
      logic               direction;
      logic               disk_select;
      logic [ADDR_W-1:0]  disk_byte_address;
      logic [BLOCK_W-1:0] segment_bytes;
      logic [LEN_W-1:0]   buffer_position;
      logic               last_segment;
      logic               too_many_blocks;
   } rsp_type;

   typedef struct packed {
      logic               done;
      logic               odd;
      logic [BLOCK_W-1:0] rem;
   } div_result_type;

endpackage

// ----- hdl/raid0_stripe_request_splitter.sv -----
// top level of the two-disk raid0 stripe request splitter
// depends on r0split_pkg, r0split_divider, r0split_walker and the defines header
`timescale 1ns / 1ps
`include "raid0_stripe_request_splitter_defines.svh"

// Usage
//   Request channel: drive req_item and raise start; the item is taken at a
//   clock edge where start is high and busy is low. busy stays high until the
//   last segment of the item is on the result ports.
//   Result channel: each segment is shown for one cycle with rsp_strobe high;
//   the receiver cannot stall and must take every strobed item.
//   Config: csr_write_enable with csr_write_data sets the stripe block size in
//   bytes (0 acts as 1); write it only while busy is low.
// Timing
//   The offset is divided by the block size in a bit-serial divider, one
//   offset bit per cycle. The walker then loads the divider result and emits
//   the segments from its output register, one segment per cycle. busy covers
//   the whole item; the next item can be taken on the cycle its
//   last segment is shown. Oversized and empty requests give one result.
// Reset
//   Clears the control state and sets the block size to 512 bytes.

module raid0_stripe_request_splitter import r0split_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   output logic               rsp_strobe,
   output rsp_type            rsp_item,
   input  logic               csr_write_enable,
   input  logic [BLOCK_W-1:0] csr_write_data
);

   logic [BLOCK_W-1:0] block_bytes_ff, block_bytes_in;
   req_type            req_hold_ff, req_hold_in;
   logic [BLOCK_W-1:0] block_eff;
   logic               launch;
   logic               div_busy;
   logic               walk_busy;
   div_result_type     div_result;

   assign launch    = start && !busy;
   assign busy      = div_busy | walk_busy;
   assign block_eff = (block_bytes_ff == '0) ? BLOCK_W'(1) : block_bytes_ff;

   assign block_bytes_in = csr_write_enable ? csr_write_data : block_bytes_ff;
   assign req_hold_in    = launch ? req_item : req_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= BLOCK_RESET;
      end else begin
         block_bytes_ff <= block_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      req_hold_ff <= req_hold_in;
   end

   r0split_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .launch   (launch),
      .dividend (req_item.volume_byte_offset),
      .divisor  (block_eff),
      .busy     (div_busy),
      .result   (div_result)
   );

   r0split_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .div_result  (div_result),
      .req_hold    (req_hold_ff),
      .block_bytes (block_eff),
      .busy        (walk_busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

   // segments of one item come out on consecutive cycles
   `R0S_ASSERT_NEXT(a_segments_contiguous, rsp_strobe && !rsp_item.last_segment, rsp_strobe)
   // an overflow flag always closes the item
   `R0S_ASSERT_SAME(a_many_is_last, rsp_strobe && rsp_item.too_many_blocks, rsp_item.last_segment)
   // only the final segment may be empty
   `R0S_ASSERT_SAME(a_mid_nonempty, rsp_strobe && !rsp_item.last_segment, rsp_item.segment_bytes != '0)
   // an accepted item keeps the block busy
   `R0S_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

endmodule

// ----- hdl/r0split_divider.sv -----
// bit-serial restoring divider: remainder and quotient parity of offset / block size
// depends on r0split_pkg
`timescale 1ns / 1ps

module r0split_divider import r0split_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                launch,
   input  logic [OFFSET_W-1:0] dividend,
   input  logic [BLOCK_W-1:0]  divisor,
   output logic                busy,
   output div_result_type      result
);

   logic [OFFSET_W-1:0]    shift_ff, shift_in;
   logic [BLOCK_W-1:0]     rem_ff, rem_in;
   logic [DIV_COUNT_W-1:0] count_ff, count_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic                   odd_ff, odd_in;
   logic [BLOCK_W:0]       trial;
   logic [BLOCK_W:0]       diff;
   logic                   ge;

   // one dividend bit enters the partial remainder per cycle
   assign trial = {rem_ff, shift_ff[OFFSET_W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      run_in   = run_ff;
      odd_in   = odd_ff;
      done_in  = run_ff && (count_ff == '0);
      if (launch) begin
         shift_in = dividend;
         rem_in   = '0;
         count_in = DIV_COUNT_W'(DIV_STEPS - 1);
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[OFFSET_W-2:0], 1'b0};
         rem_in   = ge ? diff[BLOCK_W-1:0] : trial[BLOCK_W-1:0];
         count_in = count_ff - DIV_COUNT_W'(1);
         if (count_ff == '0) begin
            run_in = 1'b0;
            // last quotient bit is the block parity
            odd_in = ge;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      odd_ff   <= odd_in;
   end

   assign busy        = run_ff | done_ff;
   assign result.done = done_ff;
   assign result.odd  = odd_ff;
   assign result.rem  = rem_ff;

endmodule

// ----- hdl/r0split_walker.sv -----
// segment walker: one result per stripe block touched, one if oversized; one per cycle
// depends on r0split_pkg
`timescale 1ns / 1ps

module r0split_walker import r0split_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_result_type     div_result,
   input  req_type            req_hold,
   input  logic [BLOCK_W-1:0] block_bytes,
   output logic               busy,
   output logic               rsp_strobe,
   output rsp_type            rsp_item
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic               state_ff, state_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [BLOCK_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0]   remaining_ff, remaining_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic               odd_ff, odd_in;
   logic               dir_ff, dir_in;
   logic               many_ff, many_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic [SPAN_W-1:0]   span;
   logic [SPAN_W-1:0]   limit;
   logic [OFFSET_W-1:0] first_base;
   logic [BLOCK_W-1:0]  avail;
   logic                fin;
   logic [BLOCK_W-1:0]  seg;

   // load-time values: last byte's distance from block start and disk base of first block
   assign span  = SPAN_W'(div_result.rem) + SPAN_W'(req_hold.request_bytes) - SPAN_W'(1);
   assign limit = SPAN_W'(block_bytes) * SPAN_W'(MAX_SEGMENTS);
   assign first_base = req_hold.volume_byte_offset - OFFSET_W'(div_result.rem)
                       - (div_result.odd ? OFFSET_W'(block_bytes) : OFFSET_W'(0));

   assign avail = block_bytes - start_ff;
   assign fin   = remaining_ff <= LEN_W'(avail);
   assign seg   = fin ? remaining_ff[BLOCK_W-1:0] : avail;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      start_in     = start_ff;
      remaining_in = remaining_ff;
      pos_in       = pos_ff;
      odd_in       = odd_ff;
      dir_in       = dir_ff;
      many_in      = many_ff;
      strobe_in    = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (div_result.done) begin
               state_in     = ST_EMIT;
               base_in      = first_base[OFFSET_W-1:1];
               start_in     = div_result.rem;
               remaining_in = req_hold.request_bytes;
               pos_in       = '0;
               odd_in       = div_result.odd;
               dir_in       = req_hold.mode;
               many_in      = (req_hold.request_bytes != '0) && (span >= limit);
            end
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            if (many_ff) begin
               rsp_in.direction         = dir_ff;
               rsp_in.disk_select       = 1'b0;
               rsp_in.disk_byte_address = '0;
               rsp_in.segment_bytes     = '0;
               rsp_in.buffer_position   = '0;
               rsp_in.last_segment      = 1'b1;
               rsp_in.too_many_blocks   = 1'b1;
               state_in                 = ST_IDLE;
            end else begin
               rsp_in.direction         = dir_ff;
               rsp_in.disk_select       = odd_ff;
               rsp_in.disk_byte_address = base_ff + ADDR_W'(start_ff);
               rsp_in.segment_bytes     = seg;
               rsp_in.buffer_position   = pos_ff;
               rsp_in.last_segment      = fin;
               rsp_in.too_many_blocks   = 1'b0;
               remaining_in             = remaining_ff - LEN_W'(seg);
               pos_in                   = pos_ff + LEN_W'(seg);
               start_in                 = '0;
               // the disk block index steps after every odd volume block
               base_in  = odd_ff ? base_ff + ADDR_W'(block_bytes) : base_ff;
               odd_in   = ~odd_ff;
               if (fin) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      start_ff     <= start_in;
      remaining_ff <= remaining_in;
      pos_ff       <= pos_in;
      odd_ff       <= odd_in;
      dir_ff       <= dir_in;
      many_ff      <= many_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = state_ff == ST_EMIT;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- test/tb.sv -----
// self-checking bench for raid0_stripe_request_splitter
// depends on r0split_pkg and the splitter rtl; predicts every segment and checks it
`timescale 1ns / 1ps

module tb;
   import r0split_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_SIZE = 50;
   localparam int TAIL_CYCLES    = 80;

   typedef struct packed {
      logic    fixed;
      req_type req;
      rsp_type want;
   } probe_row_type;

   localparam rsp_type NO_LITERAL = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_item = '0;
   logic               rsp_strobe;
   rsp_type            rsp_item;
   logic               csr_write_enable = 1'b0;
   logic [BLOCK_W-1:0] csr_write_data = '0;

   logic [BLOCK_W-1:0] block_bytes = BLOCK_RESET;
   rsp_type            expected_segments[$];
   int                 failures = 0;
   int                 idle_cycles = 0;
   int                 burst_left = 0;
   bit                 gaps_on = 1'b1;
   logic [BLOCK_W-1:0] block_sizes[9];

   // fixed rows are single results that can be read straight off the striping rule
   probe_row_type directed_rows[17] = '{
      '{1'b1, '{1'b0, 48'd0, 25'd0}, '{1'b0, 1'b0, 47'd0, 17'd0, 25'd0, 1'b1, 1'b0}},
      '{1'b1, '{1'b1, 48'd0, 25'd512}, '{1'b1, 1'b0, 47'd0, 17'd512, 25'd0, 1'b1, 1'b0}},
      '{1'b1, '{1'b0, 48'd512, 25'd1}, '{1'b0, 1'b1, 47'd0, 17'd1, 25'd0, 1'b1, 1'b0}},
      '{1'b1, '{1'b1, 48'd1024, 25'd512}, '{1'b1, 1'b0, 47'd512, 17'd512, 25'd0, 1'b1, 1'b0}},
      '{1'b1, '{1'b1, 48'd0, 25'd32769}, '{1'b1, 1'b0, 47'd0, 17'd0, 25'd0, 1'b1, 1'b1}},
      '{1'b0, '{1'b0, 48'd0, 25'd32768}, NO_LITERAL},
      '{1'b0, '{1'b1, 48'd1, 25'd32767}, NO_LITERAL},
      '{1'b1, '{1'b0, 48'd1, 25'd32768}, '{1'b0, 1'b0, 47'd0, 17'd0, 25'd0, 1'b1, 1'b1}},
      '{1'b1, '{1'b1, 48'hFFFF_FFFF_FFFF, 25'd0},
         '{1'b1, 1'b1, 47'h7FFF_FFFF_FFFF, 17'd0, 25'd0, 1'b1, 1'b0}},
      '{1'b1, '{1'b0, 48'hFFFF_FFFF_FFFF, 25'd1},
         '{1'b0, 1'b1, 47'h7FFF_FFFF_FFFF, 17'd1, 25'd0, 1'b1, 1'b0}},
      '{1'b1, '{1'b1, 48'hFFFF_FFFF_FFFF, 25'h1FF_FFFF},
         '{1'b1, 1'b0, 47'd0, 17'd0, 25'd0, 1'b1, 1'b1}},
      '{1'b1, '{1'b0, 48'd0, 25'h100_0000}, '{1'b0, 1'b0, 47'd0, 17'd0, 25'd0, 1'b1, 1'b1}},
      '{1'b0, '{1'b0, 48'd511, 25'd2}, NO_LITERAL},
      '{1'b0, '{1'b1, 48'd100, 25'd1000}, NO_LITERAL},
      '{1'b0, '{1'b0, 48'hFFFF_FFFF_FF00, 25'd4096}, NO_LITERAL},
      '{1'b0, '{1'b1, 48'h8000_0000_0000, 25'd1536}, NO_LITERAL},
      '{1'b0, '{1'b0, 48'hAAAA_AAAA_AAAA, 25'h0AA_AAAA}, NO_LITERAL}
   };

   raid0_stripe_request_splitter dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // cuts a request into its per-block segments, or one result if oversized
   function automatic void split_request(input req_type r);
      logic [63:0] bsz, off, len, first, lastb, b, start_b, end_b, pos;
      rsp_type seg;
      bsz = (block_bytes == '0) ? 64'd1 : 64'(block_bytes);
      off = 64'(r.volume_byte_offset);
      len = 64'(r.request_bytes);
      first = off / bsz;
      seg = '0;
      seg.direction = r.mode;
      seg.last_segment = 1'b1;
      if (len == 64'd0) begin
         seg.disk_select = first[0];
         seg.disk_byte_address = ADDR_W'((first >> 1) * bsz + off % bsz);
         expected_segments.push_back(seg);
         return;
      end
      lastb = (off + len - 64'd1) / bsz;
      if (lastb - first >= 64'(MAX_SEGMENTS)) begin
         seg.too_many_blocks = 1'b1;
         expected_segments.push_back(seg);
         return;
      end
      pos = 64'd0;
      for (b = first; b <= lastb; b++) begin
         start_b = (b == first) ? off % bsz : 64'd0;
         end_b = (b == lastb) ? (off + len - 64'd1) % bsz + 64'd1 : bsz;
         seg.disk_select = b[0];
         seg.disk_byte_address = ADDR_W'((b >> 1) * bsz + start_b);
         seg.segment_bytes = BLOCK_W'(end_b - start_b);
         seg.buffer_position = LEN_W'(pos);
         seg.last_segment = (b == lastb);
         expected_segments.push_back(seg);
         pos += end_b - start_b;
      end
   endfunction

   // mostly requests that fit the segment limit, sized from the current block size
   function automatic req_type random_request();
      logic [63:0] bsz, blocks, off, len;
      int kind;
      req_type r;
      bsz = (block_bytes == '0) ? 64'd1 : 64'(block_bytes);
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0, 1: off = {$urandom, $urandom};
         2: off = 64'($urandom_range(0, 7)) * bsz + 64'($urandom) % bsz;
         default: off = 64'h0000_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000));
      endcase
      if (kind < 65) begin
         blocks = 64'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 8));
         len = (blocks - 64'd1) * bsz + 64'($urandom_range(1, 32'(bsz)));
      end else if (kind < 75) begin
         len = 64'd0;
      end else if (kind < 87) begin
         // right at the segment limit, either side depending on alignment
         len = 64'd64 * bsz + 64'($urandom) % bsz;
      end else begin
         len = 64'($urandom);
      end
      r.mode = 1'($urandom_range(0, 1));
      r.volume_byte_offset = off[OFFSET_W-1:0];
      r.request_bytes = len[LEN_W-1:0];
      return r;
   endfunction

   task automatic note_failure(input string what, input rsp_type want, input rsp_type got);
      if (failures < 10) begin
         $display("%0t %s: expected dir %0d disk %0d addr %h bytes %0d pos %0d",
                  $realtime, what,
                  want.direction, want.disk_select, want.disk_byte_address,
                  want.segment_bytes, want.buffer_position);
         $display("   expected last %0d many %0d", want.last_segment,
                  want.too_many_blocks);
         $display("   got dir %0d disk %0d addr %h bytes %0d pos %0d last %0d many %0d",
                  got.direction, got.disk_select, got.disk_byte_address,
                  got.segment_bytes, got.buffer_position, got.last_segment,
                  got.too_many_blocks);
      end
      failures++;
   endtask

   task automatic drive_request(input req_type r, input logic fixed, input rsp_type want);
      int gap;
      @(negedge clock);
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (fixed)
         expected_segments.push_back(want);
      else
         split_request(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         if (gaps_on) begin
            gap = $urandom_range(1, 80);
            @(negedge clock) start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // drop start and wait for every predicted segment to come back
   task automatic drain_requests();
      @(negedge clock) start <= 1'b0;
      while (expected_segments.size() != 0 || busy) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_segments.size() == 0) begin
            note_failure("unexpected segment", NO_LITERAL, rsp_item);
         end else begin
            if (rsp_item.direction !== expected_segments[0].direction ||
                rsp_item.disk_select !== expected_segments[0].disk_select ||
                rsp_item.disk_byte_address !== expected_segments[0].disk_byte_address ||
                rsp_item.segment_bytes !== expected_segments[0].segment_bytes ||
                rsp_item.buffer_position !== expected_segments[0].buffer_position ||
                rsp_item.last_segment !== expected_segments[0].last_segment ||
                rsp_item.too_many_blocks !== expected_segments[0].too_many_blocks)
               note_failure("segment mismatch", expected_segments[0], rsp_item);
            void'(expected_segments.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      block_sizes = '{17'd1, 17'd0, 17'd65536, 17'h1FFFF, 17'd3, 17'd1000, 17'd4096,
                      BLOCK_W'($urandom_range(2, 2000)), BLOCK_RESET};
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[i])
         drive_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

      foreach (block_sizes[p]) begin
         drain_requests();
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data <= block_sizes[p];
         @(negedge clock);
         csr_write_enable <= 1'b0;
         block_bytes = block_sizes[p];
         // every third block size runs back to back with no sender gaps
         gaps_on = (p % 3 != 0);
         repeat (ITEMS_PER_SIZE) drive_request(random_request(), 1'b0, NO_LITERAL);
      end

      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_segments.size() != 0)
         failures++;
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
